### sv/tft_pkg.sv
// Shared types and constants for the TCP flow tracking table.
// No dependencies; every other file imports this package.
package tft_pkg;

  localparam int TFT_SET_COUNT = 1024;
  localparam int TFT_WAY_COUNT = 4;
  localparam int WAY_IDX_W     = 4;

  localparam logic [15:0] HASH_LOW_MASK = 16'h00ff;
  localparam logic [31:0] U32_MAX       = 32'hffff_ffff;

  localparam int FLAG_FIN_BIT = 0;
  localparam int FLAG_ACK_BIT = 4;

  localparam logic [2:0] CS_CLOSED      = 3'd0;
  localparam logic [2:0] CS_ESTABLISHED = 3'd1;
  localparam logic [2:0] CS_FIN_WAIT_1  = 3'd2;
  localparam logic [2:0] CS_PEER_FIN    = 3'd3;
  localparam logic [2:0] CS_FIN_ACKED   = 3'd4;
  localparam logic [2:0] CS_LAST_ACK    = 3'd5;
  localparam logic [2:0] CS_FIN_BOTH    = 3'd6;

  localparam logic [1:0] EV_UPDATED  = 2'd0;
  localparam logic [1:0] EV_INSERTED = 2'd1;
  localparam logic [1:0] EV_CLOSED   = 2'd2;
  localparam logic [1:0] EV_DROPPED  = 2'd3;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  tcp_flag_bits;
    logic [15:0] payload_len;
  } pkt_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [31:0] flow_src_addr;
    logic [31:0] flow_dst_addr;
    logic [15:0] flow_src_port;
    logic [15:0] flow_dst_port;
    logic [31:0] up_bytes;
    logic [31:0] down_bytes;
    logic [31:0] up_pkts;
    logic [31:0] down_pkts;
    logic [2:0]  conn_state;
  } res_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] up_bytes;
    logic [31:0] down_bytes;
    logic [31:0] up_pkts;
    logic [31:0] down_pkts;
    logic [2:0]  conn_state;
  } entry_t;

  typedef struct packed {
    logic                 hit;
    logic                 up;
    logic [WAY_IDX_W-1:0] hit_way;
    logic                 has_free;
    logic [WAY_IDX_W-1:0] free_way;
  } match_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? U32_MAX : s[31:0];
  endfunction

endpackage

### sv/tft_hash.sv
// Three-stage symmetric flow hash and set index reduction.
// Depends on tft_pkg.
module tft_hash import tft_pkg::*; #(
  parameter int SET_COUNT = TFT_SET_COUNT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  input  logic [15:0] src_port_i,
  input  logic [15:0] dst_port_i,
  output logic        done_o,
  output logic [((SET_COUNT > 1) ? $clog2(SET_COUNT) : 1)-1:0] set_o
);
  localparam int SET_W = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  // ceil(2^32 / SET_COUNT); exact quotient for every 16-bit hash
  localparam logic [32:0] RECIP =
    33'((64'h1_0000_0000 + 64'(SET_COUNT) - 64'd1) / 64'(SET_COUNT));

  logic        v1_q, v2_q, v3_q;
  logic [31:0] prod_q, addr_x_q;
  logic [15:0] h_q;
  logic [48:0] qm_q;
  logic [SET_W-1:0] set_q;

  logic [31:0] r;
  logic [15:0] h;
  logic [15:0] quo;
  logic [31:0] rem;

  always_comb begin
    r   = addr_x_q ^ prod_q;
    h   = (r[15:0] & HASH_LOW_MASK) ^ r[31:16];
    quo = qm_q[47:32];
    rem = 32'(h_q) - 32'(quo) * 32'(SET_COUNT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= 32'(src_port_i) * 32'(dst_port_i);
    addr_x_q <= src_addr_i ^ dst_addr_i;
    h_q      <= h;
    qm_q     <= 49'(h) * 49'(RECIP);
    set_q    <= rem[SET_W-1:0];
  end

  assign done_o = v3_q;
  assign set_o  = set_q;
endmodule

### sv/tft_mem.sv
// Flow table memory: one row per set holding all ways, one write and one read port.
// Depends on tft_pkg.
module tft_mem import tft_pkg::*; #(
  parameter int SET_COUNT = TFT_SET_COUNT,
  parameter int WAY_COUNT = TFT_WAY_COUNT
) (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [((SET_COUNT > 1) ? $clog2(SET_COUNT) : 1)-1:0] wr_addr_i,
  input  entry_t [WAY_COUNT-1:0]      wr_row_i,
  input  logic                        rd_en_i,
  input  logic [((SET_COUNT > 1) ? $clog2(SET_COUNT) : 1)-1:0] rd_addr_i,
  output entry_t [WAY_COUNT-1:0]      rd_row_o
);
  entry_t [WAY_COUNT-1:0] mem_q [SET_COUNT];
  entry_t [WAY_COUNT-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_row_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_row_o = rd_q;
endmodule

### sv/tft_match.sv
// Way search of one set row: first valid way matching either direction, first free way.
// Depends on tft_pkg.
module tft_match import tft_pkg::*; #(
  parameter int WAY_COUNT = TFT_WAY_COUNT
) (
  input  entry_t [WAY_COUNT-1:0] row_i,
  input  pkt_t                   pkt_i,
  output match_t                 match_o
);
  logic [WAY_COUNT-1:0] up_w, down_w;

  always_comb begin
    for (int w = 0; w < WAY_COUNT; w++) begin
      up_w[w] = row_i[w].valid &&
                row_i[w].src_addr == pkt_i.src_addr && row_i[w].dst_addr == pkt_i.dst_addr &&
                row_i[w].src_port == pkt_i.src_port && row_i[w].dst_port == pkt_i.dst_port;
      down_w[w] = row_i[w].valid &&
                row_i[w].src_addr == pkt_i.dst_addr && row_i[w].dst_addr == pkt_i.src_addr &&
                row_i[w].src_port == pkt_i.dst_port && row_i[w].dst_port == pkt_i.src_port;
    end
  end

  // priority: lowest way wins; up preferred within a way
  always_comb begin
    match_o = '0;
    for (int w = WAY_COUNT - 1; w >= 0; w--) begin
      if (up_w[w] || down_w[w]) begin
        match_o.hit     = 1'b1;
        match_o.up      = up_w[w];
        match_o.hit_way = WAY_IDX_W'(w);
      end
      if (!row_i[w].valid) begin
        match_o.has_free = 1'b1;
        match_o.free_way = WAY_IDX_W'(w);
      end
    end
  end
endmodule

### sv/tcp_flow_tracking_table_top.sv
// TCP flow tracking table: one header in, one result out per transaction.
// One item is in flight at a time: the input stays stalled from acceptance until the
// result is registered, through the hash pipeline, the set row read, the match and the row write.
// A stalled result holds the write step and the input until it is taken.
// After reset a clearing pass writes every set row, with input stalled.
// Depends on tft_pkg, tft_hash, tft_mem, tft_match.
module tcp_flow_tracking_table_top import tft_pkg::*; #(
  parameter int SET_COUNT = TFT_SET_COUNT,
  parameter int WAY_COUNT = TFT_WAY_COUNT
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  pkt_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t out_data_o
);
  localparam int SET_W = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int WAY_W = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_MATCH = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [SET_W-1:0] clr_q;
  logic [SET_W-1:0] set_q;
  pkt_t             pkt_q;
  match_t           match_q, match_d;
  res_t             out_q, res_d;
  logic             out_valid_q;

  logic                   in_acc, hash_done, go;
  logic [SET_W-1:0]       hash_set;
  entry_t [WAY_COUNT-1:0] rd_row, wr_row;
  logic                   wr_en, rd_en;
  logic [SET_W-1:0]       wr_addr;
  entry_t                 cur, upd;
  logic [2:0]             st;
  logic                   fin, ack;
  logic [WAY_W-1:0]       way_sel;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign go         = (state_q == S_WRITE) && !(out_valid_q && out_stall_i);
  assign rd_en      = (state_q == S_HASH) && hash_done;

  tft_hash #(.SET_COUNT(SET_COUNT)) u_hash (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc),
    .src_addr_i (in_data_i.src_addr),
    .dst_addr_i (in_data_i.dst_addr),
    .src_port_i (in_data_i.src_port),
    .dst_port_i (in_data_i.dst_port),
    .done_o     (hash_done),
    .set_o      (hash_set)
  );

  tft_mem #(.SET_COUNT(SET_COUNT), .WAY_COUNT(WAY_COUNT)) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_row_i  (wr_row),
    .rd_en_i   (rd_en),
    .rd_addr_i (hash_set),
    .rd_row_o  (rd_row)
  );

  tft_match #(.WAY_COUNT(WAY_COUNT)) u_match (
    .row_i   (rd_row),
    .pkt_i   (pkt_q),
    .match_o (match_d)
  );

  // Update the selected way. The row read stays in the memory's read register
  // until the next read, and one item is in flight, so no forwarding is needed.
  always_comb begin
    fin     = pkt_q.tcp_flag_bits[FLAG_FIN_BIT];
    ack     = pkt_q.tcp_flag_bits[FLAG_ACK_BIT];
    way_sel = match_q.hit ? match_q.hit_way[WAY_W-1:0] : match_q.free_way[WAY_W-1:0];
    cur     = rd_row[way_sel];
    upd     = cur;
    st      = cur.conn_state;
    res_d   = '0;
    if (match_q.hit) begin
      if (match_q.up) begin
        upd.up_bytes = sat_add(cur.up_bytes, 32'(pkt_q.payload_len));
        upd.up_pkts  = sat_add(cur.up_pkts, 32'd1);
        if (st == CS_ESTABLISHED && fin)     st = CS_FIN_WAIT_1;
        else if (st == CS_FIN_BOTH && ack)   st = CS_CLOSED;
        else if (st == CS_PEER_FIN && fin)   st = CS_LAST_ACK;
      end else begin
        upd.down_bytes = sat_add(cur.down_bytes, 32'(pkt_q.payload_len));
        upd.down_pkts  = sat_add(cur.down_pkts, 32'd1);
        if (st == CS_ESTABLISHED && fin)     st = CS_PEER_FIN;
        else if (st == CS_LAST_ACK && ack)   st = CS_CLOSED;
        else if (st == CS_FIN_WAIT_1 && ack) st = CS_FIN_ACKED;
        else if (st == CS_FIN_ACKED && fin)  st = CS_FIN_BOTH;
      end
      upd.conn_state = st;
      upd.valid      = (st != CS_CLOSED);
      res_d.event_res = (st == CS_CLOSED) ? EV_CLOSED : EV_UPDATED;
    end else begin
      upd.valid      = 1'b1;
      upd.src_addr   = pkt_q.src_addr;
      upd.dst_addr   = pkt_q.dst_addr;
      upd.src_port   = pkt_q.src_port;
      upd.dst_port   = pkt_q.dst_port;
      upd.up_bytes   = 32'(pkt_q.payload_len);
      upd.down_bytes = '0;
      upd.up_pkts    = 32'd1;
      upd.down_pkts  = '0;
      upd.conn_state = CS_ESTABLISHED;
      res_d.event_res = EV_INSERTED;
    end
    if (match_q.hit || match_q.has_free) begin
      res_d.flow_src_addr = upd.src_addr;
      res_d.flow_dst_addr = upd.dst_addr;
      res_d.flow_src_port = upd.src_port;
      res_d.flow_dst_port = upd.dst_port;
      res_d.up_bytes      = upd.up_bytes;
      res_d.down_bytes    = upd.down_bytes;
      res_d.up_pkts       = upd.up_pkts;
      res_d.down_pkts     = upd.down_pkts;
      res_d.conn_state    = upd.conn_state;
    end else begin
      res_d.event_res     = EV_DROPPED;
      res_d.flow_src_addr = pkt_q.src_addr;
      res_d.flow_dst_addr = pkt_q.dst_addr;
      res_d.flow_src_port = pkt_q.src_port;
      res_d.flow_dst_port = pkt_q.dst_port;
      res_d.conn_state    = CS_CLOSED;
    end
  end

  always_comb begin
    wr_row  = rd_row;
    wr_addr = set_q;
    wr_en   = 1'b0;
    if (state_q == S_CLEAR) begin
      wr_row  = '0;
      wr_addr = clr_q;
      wr_en   = 1'b1;
    end else if (go && (match_q.hit || match_q.has_free)) begin
      wr_row[way_sel] = upd;
      wr_en           = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == SET_W'(SET_COUNT - 1)) state_d = S_IDLE;
      S_IDLE:  if (in_acc) state_d = S_HASH;
      S_HASH:  if (hash_done) state_d = S_MATCH;
      S_MATCH: state_d = S_WRITE;
      S_WRITE: if (go) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + SET_W'(1);
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (go) out_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) pkt_q <= in_data_i;
    if (rd_en) set_q <= hash_set;
    if (state_q == S_MATCH) match_q <= match_d;
    if (go) out_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_acc_to_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_HASH) else $error("accept did not start hashing");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_q))
    else $error("stalled result overwritten");
  a_wr_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> state_q == S_CLEAR || state_q == S_WRITE) else $error("stray table write");
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && !match_q.hit && !match_q.has_free |=> out_q.up_pkts == 32'd0 && !$past(wr_en))
    else $error("dropped packet touched the table");
`endif
endmodule
